// ----- rtl/core/uvs_pkg.sv -----
// Shared types, constants and arithmetic helpers of the UV sphere quad tessellator.
package uvs_pkg;

   localparam int DEF_MAX_DIVISIONS = 256;
   localparam int DEF_CORDIC_STEPS  = 16;
   localparam int MAX_STEPS         = 24;

   localparam int IDX_W     = 8;    // stack / slice index of a request
   localparam int EXT_W     = 9;    // index plus one (vertex band / segment)
   localparam int CNT_REG_W = 9;    // count registers
   localparam int RAD_W     = 16;   // radius, Q8.8
   localparam int QUOT_W    = 33;   // floor(2^32 / n), n >= 1
   localparam int PHASE_W   = 32;   // angle phase, 2^-32 turn
   localparam int ANG_W     = 34;   // CORDIC datapath, Q2.30 plus headroom
   localparam int UNIT_W    = 16;   // Q2.14
   localparam int POS_W     = 24;   // Q9.15
   localparam int TEX_W     = 17;   // Q1.16
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;
   localparam int REQ_W     = 16;
   localparam int RSP_W     = 160;

   localparam logic signed [ANG_W-1:0] CORDIC_X0 = 34'sd652032874;
   localparam logic [PHASE_W-1:0]      RAD_SCALE = 32'd3373259426;
   localparam logic [TEX_W-1:0]        TEX_ONE   = 17'd65536;

   // Register map of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STACK_COUNT   = 2'd0,
      CSR_SLICE_COUNT   = 2'd1,
      CSR_SPHERE_RADIUS = 2'd2
   } csr_reg_type;

   // Data that rides along a vertex through the pipeline
   typedef struct packed {
      logic [TEX_W-1:0] tex_s;
      logic [TEX_W-1:0] tex_t;
      logic [1:0]       corner;
      logic             last;
      logic [1:0]       quad_r;
      logic [1:0]       quad_t;
   } vtx_side_type;

   // atan(2^-k) in Q2.30 radians, truncated
   function automatic logic signed [ANG_W-1:0] atan_q30(input int k);
      logic signed [ANG_W-1:0] v;
      unique case (k)
         0:  v = 34'sd843314856;
         1:  v = 34'sd497837829;
         2:  v = 34'sd263043836;
         3:  v = 34'sd133525158;
         4:  v = 34'sd67021686;
         5:  v = 34'sd33543515;
         6:  v = 34'sd16775850;
         7:  v = 34'sd8388437;
         8:  v = 34'sd4194282;
         9:  v = 34'sd2097149;
         10: v = 34'sd1048575;
         11: v = 34'sd524287;
         12: v = 34'sd262143;
         13: v = 34'sd131071;
         14: v = 34'sd65535;
         15: v = 34'sd32767;
         16: v = 34'sd16383;
         17: v = 34'sd8191;
         18: v = 34'sd4095;
         19: v = 34'sd2047;
         20: v = 34'sd1023;
         21: v = 34'sd511;
         22: v = 34'sd255;
         23: v = 34'sd127;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Clamp to [-1.0, 1.0] in Q2.14
   function automatic logic signed [UNIT_W-1:0] clamp_unit(input logic signed [35:0] v);
      logic signed [UNIT_W-1:0] r;
      if (v > 36'sd16384)
         r = 16'sd16384;
      else if (v < -36'sd16384)
         r = -16'sd16384;
      else
         r = v[UNIT_W-1:0];
      return r;
   endfunction

   // Q2.30 CORDIC output to Q2.14, round half up, clamped
   function automatic logic signed [UNIT_W-1:0] round_unit(input logic signed [ANG_W-1:0] v);
      logic signed [ANG_W:0] t;
      t = $signed({v[ANG_W-1], v}) + 35'sd32768;
      return clamp_unit(36'(t >>> 16));
   endfunction

endpackage

// ----- rtl/core/uvs_recip.sv -----
// Bit-serial restoring divider: floor(2^32 / n) and its remainder.
module uvs_recip import uvs_pkg::*; #(
   parameter int CNT_W = 9
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [CNT_W-1:0]  divisor,
   output logic              busy,
   output logic [QUOT_W-1:0] quot,
   output logic [CNT_W-1:0]  rem
);

   localparam int CW = $clog2(QUOT_W + 1);

   logic              run_ff;
   logic [CW-1:0]     cnt_ff;
   logic [CNT_W-1:0]  dvs_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [QUOT_W-1:0] quot_ff;
   logic [CNT_W:0]    trial;
   logic              ge;

   // Dividend is 2^32: only its top bit is set
   always_comb begin
      trial = {rem_ff, (cnt_ff == CW'(QUOT_W))};
      ge    = trial >= {1'b0, dvs_ff};
   end

   // Step control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else if (start) begin
         run_ff <= 1'b1;
      end else if (run_ff && cnt_ff == CW'(1)) begin
         run_ff <= 1'b0;
      end
   end

   // One quotient bit per cycle
   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff  <= CW'(QUOT_W);
         dvs_ff  <= divisor;
         rem_ff  <= '0;
         quot_ff <= '0;
      end else if (run_ff) begin
         cnt_ff  <= cnt_ff - 1'b1;
         rem_ff  <= ge ? CNT_W'(trial - {1'b0, dvs_ff}) : CNT_W'(trial);
         quot_ff <= {quot_ff[QUOT_W-2:0], ge};
      end
   end

   assign busy = run_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

// ----- rtl/core/uv_sphere_quad_tessellator_top.sv -----
// UV sphere quad tessellator: one quad request in, six vertices out.
// A new request can be accepted as the sixth vertex of the previous one issues.
// Throughput: one vertex per cycle while rsp_tready is high.
// Reset: counts 16/16, radius 1.0; then a reciprocal pass with req_tready low.
// Each count write starts the same reciprocal pass for that count.
module uv_sphere_quad_tessellator_top import uvs_pkg::*; #(
   parameter int MAX_DIVISIONS = DEF_MAX_DIVISIONS,
   parameter int CORDIC_STEPS  = DEF_CORDIC_STEPS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [REQ_W-1:0]     req_tdata,   // stack_index[7:0], slice_index[15:8]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata,   // pos_x, pos_y, pos_z, normal_x, normal_y,
                                             // normal_z, tex_s, tex_t, zero pad
   output logic [1:0]           rsp_tuser,   // corner
   output logic                 rsp_tlast,   // last_vertex
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   localparam int CNT_W  = $clog2(MAX_DIVISIONS + 1);
   localparam int XW     = EXT_W + CNT_W;
   localparam int PW     = XW + QUOT_W;
   localparam int NSTEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
   localparam logic [2:0] SEQ_LAST = 3'd5;

   function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_REG_W-1:0] v);
      int n;
      n = int'(v);
      if (n == 0)
         n = 1;
      else if (n > MAX_DIVISIONS)
         n = MAX_DIVISIONS;
      return CNT_W'(n);
   endfunction

   // Corner order of the two triangles
   function automatic logic [1:0] corner_of(input logic [2:0] s);
      logic [1:0] c;
      case (s)
         3'd0:    c = 2'd0;
         3'd1:    c = 2'd1;
         3'd2:    c = 2'd2;
         3'd3:    c = 2'd1;
         3'd4:    c = 2'd3;
         3'd5:    c = 2'd2;
         default: c = 2'd0;
      endcase
      return c;
   endfunction

   // ---------------- configuration ----------------
   logic [CNT_REG_W-1:0] stack_count_ff, slice_count_ff;
   logic [RAD_W-1:0]     radius_ff;
   logic                 pend_s_ff, pend_t_ff;
   logic                 csr_wr;
   logic [CNT_W-1:0]     stack_eff, slice_eff;
   logic                 busy_s, busy_t, busy;
   logic [QUOT_W-1:0]    quot_s, quot_t;
   logic [CNT_W-1:0]     rem_s, rem_t;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign stack_eff = eff_count(stack_count_ff);
   assign slice_eff = eff_count(slice_count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         stack_count_ff <= CNT_REG_W'(16);
         slice_count_ff <= CNT_REG_W'(16);
         radius_ff      <= RAD_W'(256);
         pend_s_ff      <= 1'b1;
         pend_t_ff      <= 1'b1;
      end else begin
         pend_s_ff <= 1'b0;
         pend_t_ff <= 1'b0;
         if (csr_wr && csr_index == CSR_STACK_COUNT) begin
            stack_count_ff <= csr_data[CNT_REG_W-1:0];
            pend_s_ff      <= 1'b1;
         end
         if (csr_wr && csr_index == CSR_SLICE_COUNT) begin
            slice_count_ff <= csr_data[CNT_REG_W-1:0];
            pend_t_ff      <= 1'b1;
         end
         if (csr_wr && csr_index == CSR_SPHERE_RADIUS) begin
            radius_ff <= csr_data;
         end
      end
   end

   uvs_recip #(.CNT_W(CNT_W)) u_recip_s (
      .clock(clock), .reset(reset), .start(pend_s_ff), .divisor(stack_eff),
      .busy(busy_s), .quot(quot_s), .rem(rem_s)
   );

   uvs_recip #(.CNT_W(CNT_W)) u_recip_t (
      .clock(clock), .reset(reset), .start(pend_t_ff), .divisor(slice_eff),
      .busy(busy_t), .quot(quot_t), .rem(rem_t)
   );

   assign busy = pend_s_ff || pend_t_ff || busy_s || busy_t;

   // ---------------- request register and vertex sequencer ----------------
   logic             item_v_ff;
   logic [IDX_W-1:0] item_i_ff, item_j_ff;
   logic [2:0]       seq_ff;
   logic [IDX_W-1:0] req_i, req_j, sat_i, sat_j;
   logic             adv, emit, accept, seq_end;
   logic [1:0]       cur_corner;
   logic             out_vld_ff;

   assign adv        = !out_vld_ff || rsp_tready;
   assign emit       = item_v_ff && adv;
   assign seq_end    = seq_ff == SEQ_LAST;
   assign req_tready = !busy && (!item_v_ff || (adv && seq_end));
   assign accept     = req_tvalid && req_tready;
   assign req_i      = req_tdata[IDX_W-1:0];
   assign req_j      = req_tdata[2*IDX_W-1:IDX_W];
   assign sat_i = (32'(req_i) >= 32'(stack_eff)) ? IDX_W'(stack_eff - 1'b1) : req_i;
   assign sat_j = (32'(req_j) >= 32'(slice_eff)) ? IDX_W'(slice_eff - 1'b1) : req_j;
   assign cur_corner = corner_of(seq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_v_ff <= 1'b0;
      end else if (accept) begin
         item_v_ff <= 1'b1;
      end else if (emit && seq_end) begin
         item_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_i_ff <= sat_i;
         item_j_ff <= sat_j;
         seq_ff    <= '0;
      end else if (emit && !seq_end) begin
         seq_ff <= seq_ff + 1'b1;
      end
   end

   // ---------------- s0: vertex band and segment ----------------
   logic             v0_ff;
   logic [EXT_W-1:0] b0_ff, c0_ff;
   vtx_side_type     side0_ff;
   vtx_side_type     side0_in;

   always_comb begin
      side0_in        = '0;
      side0_in.corner = cur_corner;
      side0_in.last   = seq_end;
   end

   always_ff @(posedge clock) begin
      if (reset)
         v0_ff <= 1'b0;
      else if (adv)
         v0_ff <= emit;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b0_ff    <= EXT_W'(item_i_ff) + EXT_W'(cur_corner[0]);
         c0_ff    <= EXT_W'(item_j_ff) + EXT_W'(cur_corner[1]);
         side0_ff <= side0_in;
      end
   end

   // ---------------- s1..s4: P = floor(k * 2^32 / n) = k*Q + floor(k*R / n) -------
   logic              v1_ff, v2_ff, v3_ff, v4_ff;
   vtx_side_type      side1_ff, side2_ff, side3_ff, side4_ff;
   logic [QUOT_W-1:0] cq1_s_ff, cq1_t_ff, cq2_s_ff, cq2_t_ff, cq3_s_ff, cq3_t_ff;
   logic [XW-1:0]     x1_s_ff, x1_t_ff, x2_s_ff, x2_t_ff, x3_s_ff, x3_t_ff;
   logic [XW-1:0]     q2_s_ff, q2_t_ff, q3_s_ff, q3_t_ff, nq3_s_ff, nq3_t_ff;
   logic [QUOT_W-1:0] p4_s_ff, p4_t_ff;
   logic [PW-1:0]     m_s, m_t;
   logic [XW-1:0]     d_s, d_t;
   logic              corr_s, corr_t;

   assign m_s    = PW'(x1_s_ff) * PW'(quot_s);
   assign m_t    = PW'(x1_t_ff) * PW'(quot_t);
   assign d_s    = x3_s_ff - nq3_s_ff;
   assign d_t    = x3_t_ff - nq3_t_ff;
   assign corr_s = d_s >= XW'(stack_eff);
   assign corr_t = d_t >= XW'(slice_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // k*Q and k*R
         cq1_s_ff <= QUOT_W'(b0_ff * quot_s);
         cq1_t_ff <= QUOT_W'(c0_ff * quot_t);
         x1_s_ff  <= XW'(b0_ff) * XW'(rem_s);
         x1_t_ff  <= XW'(c0_ff) * XW'(rem_t);
         side1_ff <= side0_ff;
         // estimate of floor(x / n) through the reciprocal
         q2_s_ff  <= m_s[32 +: XW];
         q2_t_ff  <= m_t[32 +: XW];
         x2_s_ff  <= x1_s_ff;
         x2_t_ff  <= x1_t_ff;
         cq2_s_ff <= cq1_s_ff;
         cq2_t_ff <= cq1_t_ff;
         side2_ff <= side1_ff;
         // estimate times n
         nq3_s_ff <= XW'(q2_s_ff * XW'(stack_eff));
         nq3_t_ff <= XW'(q2_t_ff * XW'(slice_eff));
         q3_s_ff  <= q2_s_ff;
         q3_t_ff  <= q2_t_ff;
         x3_s_ff  <= x2_s_ff;
         x3_t_ff  <= x2_t_ff;
         cq3_s_ff <= cq2_s_ff;
         cq3_t_ff <= cq2_t_ff;
         side3_ff <= side2_ff;
         // estimate is low by at most one
         p4_s_ff  <= cq3_s_ff + QUOT_W'(q3_s_ff) + QUOT_W'(corr_s);
         p4_t_ff  <= cq3_t_ff + QUOT_W'(q3_t_ff) + QUOT_W'(corr_t);
         side4_ff <= side3_ff;
      end
   end

   // ---------------- s5 and CORDIC stages ----------------
   logic                    cv_ff [NSTEPS+1];
   vtx_side_type            cside_ff [NSTEPS+1];
   logic signed [ANG_W-1:0] rx_ff [NSTEPS+1];
   logic signed [ANG_W-1:0] ry_ff [NSTEPS+1];
   logic signed [ANG_W-1:0] rz_ff [NSTEPS+1];
   logic signed [ANG_W-1:0] tx_ff [NSTEPS+1];
   logic signed [ANG_W-1:0] ty_ff [NSTEPS+1];
   logic signed [ANG_W-1:0] tz_ff [NSTEPS+1];
   logic [PHASE_W-1:0]      ph_r, ph_t;
   logic [61:0]             zm_r, zm_t;
   vtx_side_type            cside_in;

   // rho phase is P/2 (half turn span); theta phase wraps mod 2^32
   assign ph_r = p4_s_ff[PHASE_W:1];
   assign ph_t = p4_t_ff[PHASE_W-1:0];
   assign zm_r = 62'(ph_r[29:0]) * 62'(RAD_SCALE);
   assign zm_t = 62'(ph_t[29:0]) * 62'(RAD_SCALE);

   // quadrant split and texture
   always_comb begin
      cside_in        = side4_ff;
      cside_in.quad_r = ph_r[31:30];
      cside_in.quad_t = ph_t[31:30];
      cside_in.tex_t  = TEX_ONE - p4_s_ff[QUOT_W-1:16];
      cside_in.tex_s  = p4_t_ff[QUOT_W-1:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NSTEPS; k++)
            cv_ff[k] <= 1'b0;
      end else if (adv) begin
         cv_ff[0] <= v4_ff;
         for (int k = 0; k < NSTEPS; k++)
            cv_ff[k+1] <= cv_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // phase to radians
         rx_ff[0]    <= CORDIC_X0;
         ry_ff[0]    <= '0;
         rz_ff[0]    <= $signed(ANG_W'(zm_r[61:31]));
         tx_ff[0]    <= CORDIC_X0;
         ty_ff[0]    <= '0;
         tz_ff[0]    <= $signed(ANG_W'(zm_t[61:31]));
         cside_ff[0] <= cside_in;
         // one rotation per stage, both lanes
         for (int k = 0; k < NSTEPS; k++) begin
            cside_ff[k+1] <= cside_ff[k];
            if (!rz_ff[k][ANG_W-1]) begin
               rx_ff[k+1] <= rx_ff[k] - (ry_ff[k] >>> k);
               ry_ff[k+1] <= ry_ff[k] + (rx_ff[k] >>> k);
               rz_ff[k+1] <= rz_ff[k] - atan_q30(k);
            end else begin
               rx_ff[k+1] <= rx_ff[k] + (ry_ff[k] >>> k);
               ry_ff[k+1] <= ry_ff[k] - (rx_ff[k] >>> k);
               rz_ff[k+1] <= rz_ff[k] + atan_q30(k);
            end
            if (!tz_ff[k][ANG_W-1]) begin
               tx_ff[k+1] <= tx_ff[k] - (ty_ff[k] >>> k);
               ty_ff[k+1] <= ty_ff[k] + (tx_ff[k] >>> k);
               tz_ff[k+1] <= tz_ff[k] - atan_q30(k);
            end else begin
               tx_ff[k+1] <= tx_ff[k] + (ty_ff[k] >>> k);
               ty_ff[k+1] <= ty_ff[k] - (tx_ff[k] >>> k);
               tz_ff[k+1] <= tz_ff[k] + atan_q30(k);
            end
         end
      end
   end

   // ---------------- quadrant map and rounding ----------------
   logic                    mv_ff;
   vtx_side_type            mside_ff;
   logic signed [UNIT_W-1:0] rc_ff, rs_ff, tc_ff, ts_ff;
   logic signed [ANG_W-1:0] rc_in, rs_in, tc_in, ts_in;
   logic signed [ANG_W-1:0] fx_r, fy_r, fx_t, fy_t;

   assign fx_r = rx_ff[NSTEPS];
   assign fy_r = ry_ff[NSTEPS];
   assign fx_t = tx_ff[NSTEPS];
   assign fy_t = ty_ff[NSTEPS];

   always_comb begin
      unique case (cside_ff[NSTEPS].quad_r)
         2'd0: begin rc_in = fx_r;  rs_in = fy_r;  end
         2'd1: begin rc_in = -fy_r; rs_in = fx_r;  end
         2'd2: begin rc_in = -fx_r; rs_in = -fy_r; end
         2'd3: begin rc_in = fy_r;  rs_in = -fx_r; end
      endcase
      unique case (cside_ff[NSTEPS].quad_t)
         2'd0: begin tc_in = fx_t;  ts_in = fy_t;  end
         2'd1: begin tc_in = -fy_t; ts_in = fx_t;  end
         2'd2: begin tc_in = -fx_t; ts_in = -fy_t; end
         2'd3: begin tc_in = fy_t;  ts_in = -fx_t; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         mv_ff <= 1'b0;
      else if (adv)
         mv_ff <= cv_ff[NSTEPS];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rc_ff    <= round_unit(rc_in);
         rs_ff    <= round_unit(rs_in);
         tc_ff    <= round_unit(tc_in);
         ts_ff    <= round_unit(ts_in);
         mside_ff <= cside_ff[NSTEPS];
      end
   end

   // ---------------- normal products ----------------
   logic                     nv_ff;
   vtx_side_type             nside_ff;
   logic signed [UNIT_W-1:0] nx_ff, ny_ff, nz_ff;
   logic signed [UNIT_W:0]   neg_ts;
   logic signed [2*UNIT_W+1:0] prod_x, prod_y;

   assign neg_ts = -$signed({ts_ff[UNIT_W-1], ts_ff});
   assign prod_x = neg_ts * $signed({rs_ff[UNIT_W-1], rs_ff});
   assign prod_y = $signed({tc_ff[UNIT_W-1], tc_ff}) * $signed({rs_ff[UNIT_W-1], rs_ff});

   always_ff @(posedge clock) begin
      if (reset)
         nv_ff <= 1'b0;
      else if (adv)
         nv_ff <= mv_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nx_ff    <= clamp_unit(36'((36'(prod_x) + 36'sd8192) >>> 14));
         ny_ff    <= clamp_unit(36'((36'(prod_y) + 36'sd8192) >>> 14));
         nz_ff    <= rc_ff;
         nside_ff <= mside_ff;
      end
   end

   // ---------------- positions and output register ----------------
   logic signed [UNIT_W:0]   rad_s;
   logic signed [2*UNIT_W+3:0] pp_x, pp_y, pp_z;
   logic [POS_W-1:0]         px_ff, py_ff, pz_ff;
   logic [UNIT_W-1:0]        onx_ff, ony_ff, onz_ff;
   vtx_side_type             oside_ff;

   assign rad_s = $signed({1'b0, radius_ff});
   assign pp_x  = (36'(nx_ff) * 36'(rad_s)) + 36'sd64;
   assign pp_y  = (36'(ny_ff) * 36'(rad_s)) + 36'sd64;
   assign pp_z  = (36'(nz_ff) * 36'(rad_s)) + 36'sd64;

   always_ff @(posedge clock) begin
      if (reset)
         out_vld_ff <= 1'b0;
      else if (adv)
         out_vld_ff <= nv_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff    <= POS_W'(pp_x >>> 7);
         py_ff    <= POS_W'(pp_y >>> 7);
         pz_ff    <= POS_W'(pp_z >>> 7);
         onx_ff   <= nx_ff;
         ony_ff   <= ny_ff;
         onz_ff   <= nz_ff;
         oside_ff <= nside_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {6'd0, oside_ff.tex_t, oside_ff.tex_s, onz_ff, ony_ff, onx_ff,
                        pz_ff, py_ff, px_ff};
   assign rsp_tuser  = oside_ff.corner;
   assign rsp_tlast  = oside_ff.last;

endmodule

// ----- rtl/core/uvs_checker.sv -----
// Port-level checks on the tessellator, bound to the top level.
module uvs_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [15:0]  req_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [159:0] rsp_tdata,
   input logic [1:0]   rsp_tuser,
   input logic         rsp_tlast,
   input logic         csr_valid,
   input logic         csr_ready,
   input logic [1:0]   csr_index,
   input logic [15:0]  csr_data
);

   localparam logic [1:0] CORNER_TOP_RIGHT = 2'd2;

   // sixth vertex of a quad is always the top-right corner
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == CORNER_TOP_RIGHT)
      else $error("last vertex not on top-right corner");

   // reciprocal pass after reset keeps both sides quiet
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("activity right after reset");

   // a stalled vertex holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled vertex changed");

   // normal_x and normal_z stay within unit range
   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[87:72]) <= 16'sd16384
                  && $signed(rsp_tdata[87:72]) >= -16'sd16384
                  && $signed(rsp_tdata[119:104]) <= 16'sd16384
                  && $signed(rsp_tdata[119:104]) >= -16'sd16384)
      else $error("normal out of range");

   // texture coordinates never exceed 1.0
   a_tex_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[136:120] <= 17'd65536 && rsp_tdata[153:137] <= 17'd65536)
      else $error("texture coordinate out of range");

endmodule

bind uv_sphere_quad_tessellator_top uvs_checker u_uvs_checker (.*);
